FILE: rtl/stadium_track_position_top_defines.svh
// Assertion macros for the files that check their own logic; the top file includes them.
`ifndef STADIUM_TRACK_POSITION_TOP_DEFINES_SVH
`define STADIUM_TRACK_POSITION_TOP_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define STP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define STP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

`endif

FILE: rtl/stp_pkg.sv
package stp_pkg;

   localparam int DistW  = 32;
   localparam int LapW   = 26;
   localparam int R16W   = 20;
   localparam int S16W   = 24;
   localparam int ArcW   = 22;
   localparam int ScaleW = 16;
   localparam int RsW    = 36;
   localparam int SsW    = 40;
   localparam int QW     = 32;

   localparam logic [30:0] PiQ29     = 31'd1686629713;
   localparam logic [29:0] CordicK   = 30'd652032875;
   localparam logic [31:0] DegQ6Q20  = 32'd3844254675;
   localparam logic [14:0] HalfTurn  = 15'd11520;
   localparam logic [14:0] FullTurn  = 15'd23040;

   localparam logic [7:0] CsrRadius   = 8'd0;
   localparam logic [7:0] CsrStraight = 8'd1;
   localparam logic [7:0] CsrScale    = 8'd2;

   localparam logic [1:0] SegLower = 2'd0;
   localparam logic [1:0] SegRight = 2'd1;
   localparam logic [1:0] SegUpper = 2'd2;
   localparam logic [1:0] SegLeft  = 2'd3;

   typedef struct packed {
      logic [1:0]      seg;
      logic            blank;
      logic [LapW-1:0] lin;
   } item_type;

   typedef struct packed {
      logic [R16W-1:0]   r16;
      logic [S16W-1:0]   s16;
      logic [ScaleW-1:0] scale;
      logic [LapW-2:0]   s16arc;
      logic [LapW-1:0]   s2arc;
      logic [LapW-1:0]   lap;
      logic [RsW-1:0]    rs;
      logic [SsW-1:0]    s16scale;
   } cfg_type;

   function automatic logic [30:0] atan_q30(input int unsigned k);
      case (k)
         0:  atan_q30 = 31'd843314857;
         1:  atan_q30 = 31'd497837829;
         2:  atan_q30 = 31'd263043837;
         3:  atan_q30 = 31'd133525159;
         4:  atan_q30 = 31'd67021687;
         5:  atan_q30 = 31'd33543516;
         6:  atan_q30 = 31'd16775851;
         7:  atan_q30 = 31'd8388437;
         8:  atan_q30 = 31'd4194283;
         9:  atan_q30 = 31'd2097149;
         10: atan_q30 = 31'd1048576;
         11: atan_q30 = 31'd524288;
         12: atan_q30 = 31'd262144;
         13: atan_q30 = 31'd131072;
         14: atan_q30 = 31'd65536;
         15: atan_q30 = 31'd32768;
         16: atan_q30 = 31'd16384;
         17: atan_q30 = 31'd8192;
         18: atan_q30 = 31'd4096;
         19: atan_q30 = 31'd2048;
         20: atan_q30 = 31'd1024;
         21: atan_q30 = 31'd512;
         22: atan_q30 = 31'd256;
         23: atan_q30 = 31'd128;
         24: atan_q30 = 31'd64;
         25: atan_q30 = 31'd32;
         26: atan_q30 = 31'd16;
         27: atan_q30 = 31'd8;
         28: atan_q30 = 31'd4;
         29: atan_q30 = 31'd2;
         30: atan_q30 = 31'd1;
         default: atan_q30 = 31'd0;
      endcase
   endfunction

endpackage

FILE: rtl/stp_front.sv
module stp_front import stp_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic signed [DistW-1:0] in_distance,
   output logic                    out_valid,
   input  logic                    out_ready,
   output item_type                out_item
);

   localparam int Steps = DistW;

   logic            vld_ff [0:Steps];
   logic            neg_ff [0:Steps];
   logic            neg_in [0:Steps];
   logic [DistW-1:0] mag_ff [0:Steps-1];
   logic [DistW-1:0] mag_in [0:Steps-1];
   logic [LapW-1:0] rem_ff [0:Steps];
   logic [LapW-1:0] rem_in [0:Steps];
   logic            dv_ff;
   logic [LapW-1:0] d_ff;
   logic [LapW-1:0] d_in;
   logic            ov_ff;
   item_type        item_ff;
   item_type        item_in;
   logic            adv;

   assign adv       = !ov_ff || out_ready;
   assign in_ready  = adv;
   assign out_valid = ov_ff;
   assign out_item  = item_ff;

   // Restoring remainder of the magnitude by the lap length, one bit per stage.
   always_comb begin
      logic [LapW:0] t;
      t = '0;
      neg_in[0] = in_distance[DistW-1];
      mag_in[0] = in_distance[DistW-1] ? DistW'(-in_distance) : DistW'(in_distance);
      rem_in[0] = '0;
      for (int j = 0; j < Steps; j++) begin
         t = {rem_ff[j], mag_ff[j][DistW-1]};
         if (t >= {1'b0, cfg.lap}) begin
            rem_in[j+1] = LapW'(t - {1'b0, cfg.lap});
         end else begin
            rem_in[j+1] = t[LapW-1:0];
         end
         neg_in[j+1] = neg_ff[j];
         if (j < Steps - 1) begin
            mag_in[j+1] = {mag_ff[j][DistW-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (neg_ff[Steps] && (rem_ff[Steps] != '0)) begin
         d_in = cfg.lap - rem_ff[Steps];
      end else begin
         d_in = rem_ff[Steps];
      end
   end

   always_comb begin
      item_in.blank = (cfg.lap == '0);
      if (d_ff < {2'b0, cfg.s16}) begin
         item_in.seg = SegLower;
         item_in.lin = d_ff;
      end else if (d_ff < {1'b0, cfg.s16arc}) begin
         item_in.seg = SegRight;
         item_in.lin = LapW'(d_ff - {2'b0, cfg.s16});
      end else if (d_ff < cfg.s2arc) begin
         item_in.seg = SegUpper;
         item_in.lin = LapW'(cfg.s2arc - d_ff);
      end else begin
         item_in.seg = SegLeft;
         item_in.lin = LapW'(d_ff - cfg.s2arc);
      end
      if (item_in.blank) begin
         item_in.seg = SegLower;
         item_in.lin = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= Steps; k++) begin
            vld_ff[k] <= 1'b0;
         end
         dv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
         for (int k = 1; k <= Steps; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
         dv_ff <= vld_ff[Steps];
         ov_ff <= dv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= Steps; k++) begin
            neg_ff[k] <= neg_in[k];
            rem_ff[k] <= rem_in[k];
         end
         for (int k = 0; k < Steps; k++) begin
            mag_ff[k] <= mag_in[k];
         end
         d_ff    <= d_in;
         item_ff <= item_in;
      end
   end

endmodule

FILE: rtl/stp_queue.sv
module stp_queue import stp_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);

   item_type        mem_ff [0:DEPTH-1];
   logic [PtrW-1:0] wr_ptr_ff;
   logic [PtrW-1:0] rd_ptr_ff;
   logic [CntW-1:0] count_ff;
   logic            push;
   logic            pop;

   assign in_ready  = (count_ff != CntW'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

FILE: rtl/stp_back.sv
module stp_back import stp_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        in_valid,
   output logic        in_ready,
   input  item_type    in_item,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [23:0] out_x,
   output logic [23:0] out_y,
   output logic [14:0] out_heading,
   output logic [1:0]  out_segment
);

   localparam int DivSteps = QW;
   localparam int S        = CORDIC_STEPS;

   logic                   dv_vld_ff [0:DivSteps];
   item_type               dv_item_ff [0:DivSteps];
   item_type               dv_item_in [0:DivSteps];
   logic [R16W-1:0]        dv_rem_ff [0:DivSteps];
   logic [R16W-1:0]        dv_rem_in [0:DivSteps];
   logic [QW-1:0]          dv_q_ff [0:DivSteps];
   logic [QW-1:0]          dv_q_in [0:DivSteps];

   logic                   cv_vld_ff [0:S];
   item_type               c_item_ff [0:S];
   item_type               c_item_in [0:S];
   logic signed [33:0]     cx_ff [0:S];
   logic signed [33:0]     cx_in [0:S];
   logic signed [33:0]     cy_ff [0:S];
   logic signed [33:0]     cy_in [0:S];
   logic signed [33:0]     cz_ff [0:S];
   logic signed [33:0]     cz_in [0:S];
   logic [14:0]            chd_ff [1:S];
   logic [14:0]            chd_in [1:S];
   logic [63:0]            hp_ff;
   logic [63:0]            hp_in;

   logic                   tv_ff;
   item_type               t_item_ff;
   logic signed [28:0]     t_sn_ff;
   logic signed [28:0]     t_sn_in;
   logic signed [28:0]     t_cs_ff;
   logic signed [28:0]     t_cs_in;
   logic [14:0]            t_hd_ff;

   logic                   mv_ff;
   item_type               m_item_ff;
   logic signed [65:0]     m_ts_ff;
   logic signed [65:0]     m_ts_in;
   logic signed [65:0]     m_tc_ff;
   logic signed [65:0]     m_tc_in;
   logic [41:0]            m_lp_ff;
   logic [41:0]            m_lp_in;
   logic [14:0]            m_hd_ff;

   logic                   rv_ff;
   logic [1:0]             r_seg_ff;
   logic signed [44:0]     r_x20_ff;
   logic signed [44:0]     r_x20_in;
   logic signed [44:0]     r_y20_ff;
   logic signed [44:0]     r_y20_in;
   logic [14:0]            r_hd_ff;

   logic                   ov_ff;
   logic [23:0]            o_x_ff;
   logic [23:0]            o_y_ff;
   logic [14:0]            o_hd_ff;
   logic [1:0]             o_seg_ff;

   logic                   adv;

   function automatic logic [14:0] heading_of(input logic [63:0] prod, input logic [1:0] seg);
      logic [64:0] sum;
      logic [15:0] h;
      sum = {1'b0, prod} + (65'd1 << 49);
      h   = {1'b0, sum[64:50]};
      case (seg)
         SegLower: heading_of = '0;
         SegRight: heading_of = (h > 16'(FullTurn)) ? FullTurn : h[14:0];
         SegUpper: heading_of = HalfTurn;
         default: begin
            h          = h + 16'(HalfTurn);
            heading_of = (h > 16'(FullTurn)) ? FullTurn : h[14:0];
         end
      endcase
   endfunction

   function automatic logic [23:0] sat_round(input logic signed [44:0] v);
      logic signed [44:0] r;
      r = (v + 45'sd32768) >>> 16;
      if (r > 45'sd8388607) begin
         sat_round = 24'h7FFFFF;
      end else if (r < -45'sd8388608) begin
         sat_round = 24'h800000;
      end else begin
         sat_round = r[23:0];
      end
   endfunction

   assign adv         = !ov_ff || out_ready;
   assign in_ready    = adv;
   assign out_valid   = ov_ff;
   assign out_x       = o_x_ff;
   assign out_y       = o_y_ff;
   assign out_heading = o_hd_ff;
   assign out_segment = o_seg_ff;

   // Angle of the arc offset: (offset << 30) / (radius * 16), one quotient bit per stage.
   always_comb begin
      logic [R16W:0] t;
      logic          nbit;
      t    = '0;
      nbit = 1'b0;
      dv_item_in[0] = in_item;
      dv_rem_in[0]  = in_item.lin[R16W+1:2];
      dv_q_in[0]    = '0;
      for (int j = 0; j < DivSteps; j++) begin
         if (j == 0) begin
            nbit = dv_item_ff[j].lin[1];
         end else if (j == 1) begin
            nbit = dv_item_ff[j].lin[0];
         end else begin
            nbit = 1'b0;
         end
         t = {dv_rem_ff[j], nbit};
         if (t >= {1'b0, cfg.r16}) begin
            dv_rem_in[j+1] = R16W'(t - {1'b0, cfg.r16});
            dv_q_in[j+1]   = {dv_q_ff[j][QW-2:0], 1'b1};
         end else begin
            dv_rem_in[j+1] = t[R16W-1:0];
            dv_q_in[j+1]   = {dv_q_ff[j][QW-2:0], 1'b0};
         end
         dv_item_in[j+1] = dv_item_ff[j];
      end
   end

   // Rotation stages; the angle is shifted by a quarter turn so that x gives the sine.
   always_comb begin
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic signed [33:0] a;
      dx = '0;
      dy = '0;
      a  = '0;
      c_item_in[0] = dv_item_ff[DivSteps];
      cx_in[0]     = signed'(34'(CordicK));
      cy_in[0]     = '0;
      cz_in[0]     = signed'(34'(dv_q_ff[DivSteps])) - signed'(34'(PiQ29));
      hp_in        = 64'(dv_q_ff[DivSteps]) * 64'(DegQ6Q20);
      for (int i = 0; i < S; i++) begin
         dx = cy_ff[i] >>> i;
         dy = cx_ff[i] >>> i;
         a  = signed'(34'(atan_q30(i)));
         if (!cz_ff[i][33]) begin
            cx_in[i+1] = cx_ff[i] - dx;
            cy_in[i+1] = cy_ff[i] + dy;
            cz_in[i+1] = cz_ff[i] - a;
         end else begin
            cx_in[i+1] = cx_ff[i] + dx;
            cy_in[i+1] = cy_ff[i] - dy;
            cz_in[i+1] = cz_ff[i] + a;
         end
         c_item_in[i+1] = c_item_ff[i];
         if (i == 0) begin
            chd_in[i+1] = heading_of(hp_ff, c_item_ff[i].seg);
         end else begin
            chd_in[i+1] = chd_ff[i];
         end
      end
   end

   always_comb begin
      logic signed [34:0] sn_sum;
      logic signed [34:0] cs_sum;
      sn_sum  = 35'(cx_ff[S]) + 35'sd32;
      cs_sum  = -(35'(cy_ff[S])) + 35'sd32;
      t_sn_in = 29'(sn_sum >>> 6);
      t_cs_in = 29'(cs_sum >>> 6);
   end

   always_comb begin
      logic signed [65:0] rs_w;
      rs_w    = 66'(signed'({1'b0, cfg.rs}));
      m_ts_in = rs_w * 66'(t_sn_ff);
      m_tc_in = rs_w * 66'(t_cs_ff);
      m_lp_in = 42'(t_item_ff.lin) * 42'(cfg.scale);
   end

   always_comb begin
      logic signed [65:0] ts_w;
      logic signed [65:0] tc_w;
      logic signed [44:0] ts;
      logic signed [44:0] tc;
      logic signed [44:0] rs;
      logic signed [44:0] ss;
      logic signed [44:0] lp;
      ts_w = (m_ts_ff + 66'sd8388608) >>> 24;
      tc_w = (m_tc_ff + 66'sd8388608) >>> 24;
      ts   = 45'(ts_w);
      tc   = 45'(tc_w);
      rs   = 45'(signed'({1'b0, cfg.rs}));
      ss   = 45'(signed'({1'b0, cfg.s16scale}));
      lp   = 45'(signed'({1'b0, m_lp_ff}));
      case (m_item_ff.seg)
         SegLower: begin
            r_x20_in = lp;
            r_y20_in = -rs;
         end
         SegRight: begin
            r_x20_in = ss + ts;
            r_y20_in = -tc;
         end
         SegUpper: begin
            r_x20_in = lp;
            r_y20_in = rs;
         end
         default: begin
            r_x20_in = -ts;
            r_y20_in = tc;
         end
      endcase
      if (m_item_ff.blank) begin
         r_x20_in = '0;
         r_y20_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DivSteps; k++) begin
            dv_vld_ff[k] <= 1'b0;
         end
         for (int k = 0; k <= S; k++) begin
            cv_vld_ff[k] <= 1'b0;
         end
         tv_ff <= 1'b0;
         mv_ff <= 1'b0;
         rv_ff <= 1'b0;
         ov_ff <= 1'b0;
      end else if (adv) begin
         dv_vld_ff[0] <= in_valid;
         for (int k = 1; k <= DivSteps; k++) begin
            dv_vld_ff[k] <= dv_vld_ff[k-1];
         end
         cv_vld_ff[0] <= dv_vld_ff[DivSteps];
         for (int k = 1; k <= S; k++) begin
            cv_vld_ff[k] <= cv_vld_ff[k-1];
         end
         tv_ff <= cv_vld_ff[S];
         mv_ff <= tv_ff;
         rv_ff <= mv_ff;
         ov_ff <= rv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= DivSteps; k++) begin
            dv_item_ff[k] <= dv_item_in[k];
            dv_rem_ff[k]  <= dv_rem_in[k];
            dv_q_ff[k]    <= dv_q_in[k];
         end
         for (int k = 0; k <= S; k++) begin
            c_item_ff[k] <= c_item_in[k];
            cx_ff[k]     <= cx_in[k];
            cy_ff[k]     <= cy_in[k];
            cz_ff[k]     <= cz_in[k];
         end
         for (int k = 1; k <= S; k++) begin
            chd_ff[k] <= chd_in[k];
         end
         hp_ff     <= hp_in;
         t_item_ff <= c_item_ff[S];
         t_sn_ff   <= t_sn_in;
         t_cs_ff   <= t_cs_in;
         t_hd_ff   <= chd_ff[S];
         m_item_ff <= t_item_ff;
         m_ts_ff   <= m_ts_in;
         m_tc_ff   <= m_tc_in;
         m_lp_ff   <= m_lp_in;
         m_hd_ff   <= t_hd_ff;
         r_seg_ff  <= m_item_ff.seg;
         r_x20_ff  <= r_x20_in;
         r_y20_ff  <= r_y20_in;
         r_hd_ff   <= m_hd_ff;
         o_x_ff    <= sat_round(r_x20_ff);
         o_y_ff    <= sat_round(r_y20_ff);
         o_hd_ff   <= r_hd_ff;
         o_seg_ff  <= r_seg_ff;
      end
   end

endmodule

FILE: rtl/stadium_track_position_top.sv
// Maps a signed distance along a stadium-shaped track to pixel coordinates and a heading.
// Channels: csr_* writes the radius (index 0), straight length (1) and pixel scale (2);
// req_* takes one distance per transfer; rsp_* returns x, y, heading and segment, one
// result per request, in request order.
// Throughput is one request per cycle while nothing stalls and no register write settles.
// A result passes through a 32-stage lap remainder, a 32-stage angle divider and one
// CORDIC stage per step on its way to the output register.
// A queue of QUEUE_DEPTH entries sits between the classifier and the arc math, so the
// front keeps accepting while the back stalls until the queue fills.
// When rsp_ready is low the result holds in the output register and the back pipeline
// stops; req_ready falls once the queue is full and the front output register holds a
// transfer, and the whole front pipeline then stops.
// Reset restores the register defaults (5000, 40000, 655) and empties all stages.
// After reset and after each register write, req_ready stays low while the derived track
// lengths settle. csr_ready is always high.
`include "stadium_track_position_top_defines.svh"

module stadium_track_position_top import stp_pkg::*; #(
   parameter int CORDIC_STEPS = 16,
   parameter int QUEUE_DEPTH  = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [7:0]              csr_index,
   input  logic [31:0]             csr_data,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic signed [DistW-1:0] req_distance_q4,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [23:0]      rsp_x_px_q4,
   output logic signed [23:0]      rsp_y_px_q4,
   output logic [14:0]             rsp_heading_q6,
   output logic [1:0]              rsp_segment
);

   logic [15:0]       radius_ff;
   logic [19:0]       straight_ff;
   logic [15:0]       scale_ff;
   logic [1:0]        settle_ff;
   logic [R16W-1:0]   r16_ff;
   logic [S16W-1:0]   s16_ff;
   logic [ScaleW-1:0] sc_ff;
   logic [ArcW-1:0]   arc_ff;
   logic [RsW-1:0]    rs_ff;
   logic [SsW-1:0]    ss_ff;
   cfg_type           cfg_ff;
   logic [R16W-1:0]   r16_in;
   logic [S16W-1:0]   s16_in;
   logic [51:0]       arc_prod;
   logic              csr_write;
   logic              front_ready;
   logic              front_valid;
   item_type          front_item;
   logic              queue_ready;
   logic              queue_valid;
   item_type          queue_item;
   logic              back_ready;
   logic [23:0]       x_raw;
   logic [23:0]       y_raw;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign req_ready = front_ready && (settle_ff == '0);
   assign r16_in    = {radius_ff, 4'b0};
   assign s16_in    = {straight_ff, 4'b0};
   assign arc_prod  = 52'(r16_in) * 52'(PiQ29) + (52'd1 << 28);

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff   <= 16'd5000;
         straight_ff <= 20'd40000;
         scale_ff    <= 16'd655;
         settle_ff   <= 2'd2;
      end else begin
         if (csr_write) begin
            settle_ff <= 2'd2;
            unique case (csr_index)
               CsrRadius:   radius_ff   <= csr_data[15:0];
               CsrStraight: straight_ff <= csr_data[19:0];
               CsrScale:    scale_ff    <= csr_data[15:0];
               default:     ;
            endcase
         end else if (settle_ff != '0) begin
            settle_ff <= settle_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      r16_ff          <= r16_in;
      s16_ff          <= s16_in;
      sc_ff           <= scale_ff;
      arc_ff          <= ArcW'(arc_prod >> 29);
      rs_ff           <= RsW'(r16_in) * RsW'(scale_ff);
      ss_ff           <= SsW'(s16_in) * SsW'(scale_ff);
      cfg_ff.r16      <= r16_ff;
      cfg_ff.s16      <= s16_ff;
      cfg_ff.scale    <= sc_ff;
      cfg_ff.rs       <= rs_ff;
      cfg_ff.s16scale <= ss_ff;
      cfg_ff.s16arc   <= (LapW-1)'(s16_ff) + (LapW-1)'(arc_ff);
      cfg_ff.s2arc    <= LapW'({s16_ff, 1'b0}) + LapW'(arc_ff);
      cfg_ff.lap      <= LapW'({s16_ff, 1'b0}) + LapW'({arc_ff, 1'b0});
   end

   stp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_valid && (settle_ff == '0)),
      .in_ready    (front_ready),
      .in_distance (req_distance_q4),
      .out_valid   (front_valid),
      .out_ready   (queue_ready),
      .out_item    (front_item)
   );

   stp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (queue_ready),
      .in_item   (front_item),
      .out_valid (queue_valid),
      .out_ready (back_ready),
      .out_item  (queue_item)
   );

   stp_back #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (queue_valid),
      .in_ready    (back_ready),
      .in_item     (queue_item),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_x       (x_raw),
      .out_y       (y_raw),
      .out_heading (rsp_heading_q6),
      .out_segment (rsp_segment)
   );

   assign rsp_x_px_q4 = signed'(x_raw);
   assign rsp_y_px_q4 = signed'(y_raw);

   `STP_ASSERT_NEXT(a_csr_settle, clock, reset, csr_write, !req_ready, "request taken too soon after a register write")
   `STP_ASSERT_NOW(a_heading_max, clock, reset, rsp_valid, rsp_heading_q6 <= FullTurn, "heading above a full turn")
   `STP_ASSERT_NOW(a_lower_heading, clock, reset, rsp_valid && (rsp_segment == SegLower), rsp_heading_q6 == '0, "lower straight with nonzero heading")
   `STP_ASSERT_NOW(a_upper_heading, clock, reset, rsp_valid && (rsp_segment == SegUpper), rsp_heading_q6 == HalfTurn, "upper straight without a half-turn heading")

endmodule
